// ----- hdl/vtp_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants and types for the vertex transform and projection pipeline.
// Used by vertex_transform_project and its checker; no dependencies.
package vtp_pkg;

  localparam int unsigned COORD_W     = 32;                     // Q16.16 coordinate
  localparam int unsigned COEF_W      = 16;                     // Q4.12 coefficient
  localparam int unsigned FOCAL_W     = 31;                     // focal distance
  localparam int unsigned AXES        = 3;
  localparam int unsigned ROW_W       = AXES * COEF_W;          // packed matrix row
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned ROUND_SHIFT = 12;                     // Q20.28 -> Q16.16
  localparam int unsigned PROD_W      = COORD_W + COEF_W;       // one product
  localparam int unsigned SUM_W       = PROD_W + 2;             // three products + round
  localparam int unsigned TOT_W       = SUM_W - ROUND_SHIFT + 1; // plus translation
  localparam int unsigned NUM_W       = FOCAL_W + COORD_W;      // d * |x'|
  localparam int unsigned DIV_STEPS   = COORD_W;                // quotient bits
  localparam int unsigned PIPE_DEPTH  = DIV_STEPS + 6;          // accept to result

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW_ONE   = 3'd0,
    REG_ROW_TWO   = 3'd1,
    REG_ROW_THREE = 3'd2,
    REG_SHIFT_X   = 3'd3,
    REG_SHIFT_Y   = 3'd4,
    REG_SHIFT_Z   = 3'd5,
    REG_FOCAL     = 3'd6
  } cfg_reg_e;

  // One lane of the restoring divider
  typedef struct packed {
    logic [COORD_W-1:0] rem;
    logic [COORD_W-1:0] low;
    logic [COORD_W-1:0] quo;
  } lane_t;

  // Data that rides alongside the divider lanes
  typedef struct packed {
    logic [COORD_W-1:0] zabs;
    logic               neg_x;
    logic               neg_y;
    logic               big_x;
    logic               big_y;
    logic               ovf;
    logic               zero;
    logic [COORD_W-1:0] depth;
  } side_t;

endpackage

// ----- hdl/vertex_transform_project.sv -----
`timescale 1ns / 1ps
// Affine vertex transform (Q4.12 matrix, Q16.16 translation) and perspective
// projection, fully pipelined. Depends on vtp_pkg.
//
// Channel   | Handshake                 | Payload
// ----------+---------------------------+--------------------------------------
// point in  | start_i / busy_o          | point_x_i, point_y_i, point_z_i
// result    | out_valid_o (strobe)      | screen_x_o, screen_y_o, depth_o,
//           |                           | zero_depth_o, overflowed_o
// config    | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// One point is taken every clock; busy_o never rises. Each result passes
// registered stages for the matrix product, rounding, saturation, d*x' and
// the divider load, then the two 32-step restoring dividers, one quotient
// bit per stage, then one output register.
// Reset clears the valid chain and loads the identity matrix, zero
// translation and d = 1.0. The receiver cannot stall, so nothing ever holds.
// Config writes are taken every cycle but must only happen with the pipe empty.
module vertex_transform_project (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // point transactions
  input  logic                            start_i,
  output logic                            busy_o,
  input  logic signed [vtp_pkg::COORD_W-1:0] point_x_i,
  input  logic signed [vtp_pkg::COORD_W-1:0] point_y_i,
  input  logic signed [vtp_pkg::COORD_W-1:0] point_z_i,
  // results
  output logic                            out_valid_o,
  output logic signed [vtp_pkg::COORD_W-1:0] screen_x_o,
  output logic signed [vtp_pkg::COORD_W-1:0] screen_y_o,
  output logic signed [vtp_pkg::COORD_W-1:0] depth_o,
  output logic                            zero_depth_o,
  output logic                            overflowed_o,
  // register writes
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [vtp_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [vtp_pkg::ROW_W-1:0]       cfg_data_i
);

  localparam int unsigned CW = vtp_pkg::COORD_W;
  localparam int unsigned NS = vtp_pkg::DIV_STEPS;

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [vtp_pkg::ROW_W-1:0]   row_q   [vtp_pkg::AXES];
  logic signed [CW-1:0]        shift_q [vtp_pkg::AXES];
  logic [vtp_pkg::FOCAL_W-1:0] focal_q;

  assign cfg_ready_o = 1'b1;
  assign busy_o      = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q[0]   <= vtp_pkg::ROW_W'(48'h0000_0000_1000);
      row_q[1]   <= vtp_pkg::ROW_W'(48'h0000_1000_0000);
      row_q[2]   <= vtp_pkg::ROW_W'(48'h1000_0000_0000);
      shift_q[0] <= '0;
      shift_q[1] <= '0;
      shift_q[2] <= '0;
      focal_q    <= vtp_pkg::FOCAL_W'(31'h0001_0000);
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (vtp_pkg::cfg_reg_e'(cfg_index_i))
        vtp_pkg::REG_ROW_ONE:   row_q[0]   <= cfg_data_i;
        vtp_pkg::REG_ROW_TWO:   row_q[1]   <= cfg_data_i;
        vtp_pkg::REG_ROW_THREE: row_q[2]   <= cfg_data_i;
        vtp_pkg::REG_SHIFT_X:   shift_q[0] <= cfg_data_i[CW-1:0];
        vtp_pkg::REG_SHIFT_Y:   shift_q[1] <= cfg_data_i[CW-1:0];
        vtp_pkg::REG_SHIFT_Z:   shift_q[2] <= cfg_data_i[CW-1:0];
        vtp_pkg::REG_FOCAL:     focal_q    <= cfg_data_i[vtp_pkg::FOCAL_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Valid chain: bit k marks stage k+1
  // ---------------------------------------------------------------------
  logic                            accept;
  logic [vtp_pkg::PIPE_DEPTH-1:0]  vld_q;

  assign accept = start_i && !busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[vtp_pkg::PIPE_DEPTH-2:0], accept};
    end
  end

  assign out_valid_o = vld_q[vtp_pkg::PIPE_DEPTH-1];

  // ---------------------------------------------------------------------
  // Stage 1: nine products, prod_q[col][row] = p[row] * m[row][col]
  // ---------------------------------------------------------------------
  logic signed [CW-1:0]              pt [vtp_pkg::AXES];
  logic signed [vtp_pkg::PROD_W-1:0] prod_q [vtp_pkg::AXES][vtp_pkg::AXES];

  assign pt[0] = point_x_i;
  assign pt[1] = point_y_i;
  assign pt[2] = point_z_i;

  always_ff @(posedge clk_i) begin
    for (int c = 0; c < vtp_pkg::AXES; c++) begin
      for (int r = 0; r < vtp_pkg::AXES; r++) begin
        prod_q[c][r] <= pt[r] * $signed(row_q[r][c*vtp_pkg::COEF_W +: vtp_pkg::COEF_W]);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stage 2: column sums plus the rounding half (2^11)
  // ---------------------------------------------------------------------
  logic signed [vtp_pkg::SUM_W-1:0] sum_q [vtp_pkg::AXES];

  always_ff @(posedge clk_i) begin
    for (int c = 0; c < vtp_pkg::AXES; c++) begin
      sum_q[c] <= vtp_pkg::SUM_W'(prod_q[c][0]) + vtp_pkg::SUM_W'(prod_q[c][1])
                + vtp_pkg::SUM_W'(prod_q[c][2])
                + vtp_pkg::SUM_W'(1 << (vtp_pkg::ROUND_SHIFT - 1));
    end
  end

  // ---------------------------------------------------------------------
  // Stage 3: floor shift, translation, saturation
  // ---------------------------------------------------------------------
  logic signed [CW-1:0] tr_d [vtp_pkg::AXES];
  logic signed [CW-1:0] tr_q [vtp_pkg::AXES];
  logic                 ov3_d, ov3_q;

  always_comb begin
    logic signed [vtp_pkg::TOT_W-1:0] tot;
    logic [vtp_pkg::TOT_W-CW:0]       hi;
    ov3_d = 1'b0;
    for (int c = 0; c < vtp_pkg::AXES; c++) begin
      tot = vtp_pkg::TOT_W'($signed(sum_q[c][vtp_pkg::SUM_W-1:vtp_pkg::ROUND_SHIFT]))
          + vtp_pkg::TOT_W'(shift_q[c]);
      hi  = tot[vtp_pkg::TOT_W-1:CW-1];
      if (hi == '0 || hi == '1) begin
        tr_d[c] = tot[CW-1:0];
      end else begin
        ov3_d   = 1'b1;
        tr_d[c] = tot[vtp_pkg::TOT_W-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    tr_q  <= tr_d;
    ov3_q <= ov3_d;
  end

  // ---------------------------------------------------------------------
  // Stage 4: magnitudes and numerators d*|x'|, d*|y'|
  // ---------------------------------------------------------------------
  logic [CW-1:0]               xabs, yabs, zabs;
  logic [vtp_pkg::NUM_W-1:0]   numx_q, numy_q;
  logic [CW-1:0]               zabs_q, depth4_q;
  logic                        negx4_q, negy4_q, ov4_q, zero4_q;

  assign xabs = tr_q[0][CW-1] ? (~tr_q[0] + 1'b1) : tr_q[0];
  assign yabs = tr_q[1][CW-1] ? (~tr_q[1] + 1'b1) : tr_q[1];
  assign zabs = tr_q[2][CW-1] ? (~tr_q[2] + 1'b1) : tr_q[2];

  always_ff @(posedge clk_i) begin
    numx_q   <= focal_q * xabs;
    numy_q   <= focal_q * yabs;
    zabs_q   <= zabs;
    depth4_q <= tr_q[2];
    // -q is negative when x' and z' share a sign
    negx4_q  <= (tr_q[0][CW-1] == tr_q[2][CW-1]);
    negy4_q  <= (tr_q[1][CW-1] == tr_q[2][CW-1]);
    ov4_q    <= ov3_q;
    zero4_q  <= (tr_q[2] == '0);
  end

  // ---------------------------------------------------------------------
  // Stage 5: quotient range check and divider load
  // Stages 6..37: restoring division, one quotient bit per stage
  // ---------------------------------------------------------------------
  vtp_pkg::lane_t lane_x_q [NS+1];
  vtp_pkg::lane_t lane_y_q [NS+1];
  vtp_pkg::side_t side_q   [NS+1];

  function automatic vtp_pkg::lane_t div_step(vtp_pkg::lane_t l, logic [CW-1:0] dv);
    vtp_pkg::lane_t n;
    logic [CW:0]    r2;
    logic           ge;
    r2    = {l.rem, l.low[CW-1]};
    ge    = (r2 >= {1'b0, dv});
    n.rem = ge ? CW'(r2 - {1'b0, dv}) : r2[CW-1:0];
    n.low = {l.low[CW-2:0], 1'b0};
    n.quo = {l.quo[CW-2:0], ge};
    return n;
  endfunction

  always_ff @(posedge clk_i) begin
    lane_x_q[0].rem   <= {1'b0, numx_q[vtp_pkg::NUM_W-1:CW]};
    lane_x_q[0].low   <= numx_q[CW-1:0];
    lane_x_q[0].quo   <= '0;
    lane_y_q[0].rem   <= {1'b0, numy_q[vtp_pkg::NUM_W-1:CW]};
    lane_y_q[0].low   <= numy_q[CW-1:0];
    lane_y_q[0].quo   <= '0;
    side_q[0].zabs    <= zabs_q;
    side_q[0].neg_x   <= negx4_q;
    side_q[0].neg_y   <= negy4_q;
    // quotient of 2^32 or more cannot fit any output
    side_q[0].big_x   <= ({1'b0, numx_q} >= {zabs_q, {CW{1'b0}}});
    side_q[0].big_y   <= ({1'b0, numy_q} >= {zabs_q, {CW{1'b0}}});
    side_q[0].ovf     <= ov4_q;
    side_q[0].zero    <= zero4_q;
    side_q[0].depth   <= depth4_q;
    for (int k = 1; k <= NS; k++) begin
      lane_x_q[k] <= div_step(lane_x_q[k-1], side_q[k-1].zabs);
      lane_y_q[k] <= div_step(lane_y_q[k-1], side_q[k-1].zabs);
      side_q[k]   <= side_q[k-1];
    end
  end

  // ---------------------------------------------------------------------
  // Stage 38: negate, saturate, zero-depth override
  // ---------------------------------------------------------------------
  logic [CW-1:0] qx, qy;
  logic          negx, negy, satx, saty;
  logic [CW-1:0] sx_d, sy_d;
  logic          ovf_d;

  assign qx   = lane_x_q[NS].quo;
  assign qy   = lane_y_q[NS].quo;
  assign negx = side_q[NS].neg_x;
  assign negy = side_q[NS].neg_y;
  // negative results reach -2^31, positive ones stop at 2^31-1
  assign satx = side_q[NS].big_x || (qx[CW-1] && (!negx || (qx[CW-2:0] != '0)));
  assign saty = side_q[NS].big_y || (qy[CW-1] && (!negy || (qy[CW-2:0] != '0)));

  always_comb begin
    if (side_q[NS].zero) begin
      sx_d  = '0;
      sy_d  = '0;
      ovf_d = side_q[NS].ovf;
    end else begin
      if (satx) begin
        sx_d = negx ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
      end else begin
        sx_d = negx ? (~qx + 1'b1) : qx;
      end
      if (saty) begin
        sy_d = negy ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
      end else begin
        sy_d = negy ? (~qy + 1'b1) : qy;
      end
      ovf_d = side_q[NS].ovf || satx || saty;
    end
  end

  always_ff @(posedge clk_i) begin
    screen_x_o   <= sx_d;
    screen_y_o   <= sy_d;
    depth_o      <= side_q[NS].depth;
    zero_depth_o <= side_q[NS].zero;
    overflowed_o <= ovf_d;
  end

endmodule

// ----- hdl/vtp_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks for vertex_transform_project, bound to the top level.
// Depends on vtp_pkg for the pipeline depth.
module vtp_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                start_i,
  input logic                                busy_o,
  input logic                                out_valid_o,
  input logic signed [vtp_pkg::COORD_W-1:0]  screen_x_o,
  input logic signed [vtp_pkg::COORD_W-1:0]  screen_y_o,
  input logic signed [vtp_pkg::COORD_W-1:0]  depth_o,
  input logic                                zero_depth_o,
  input logic                                overflowed_o
);

  // every result traces back to an accepted transaction that passed the full pipe
  a_result_has_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $past(start_i && !busy_o, vtp_pkg::PIPE_DEPTH))
    else $error("result without matching transaction");

  a_zero_depth_outputs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && zero_depth_o) |->
      (screen_x_o == '0 && screen_y_o == '0 && depth_o == '0))
    else $error("zero depth result with non-zero outputs");

  a_depth_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && depth_o == '0) |-> zero_depth_o)
    else $error("zero depth not flagged");

  a_overflow_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (overflowed_o == 1'b0 || overflowed_o == 1'b1))
    else $error("overflow flag undefined on result");

endmodule

bind vertex_transform_project vtp_checker u_vtp_checker (.*);

// ----- test/vertex_transform_project_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for vertex_transform_project: affine transform,
// perspective projection, saturation and register writes. Depends on vtp_pkg.
module vertex_transform_project_tb;

  // Index 7 decodes to no register; writes there must leave everything alone
  localparam logic [vtp_pkg::CFG_IDX_W-1:0] UNMAPPED_INDEX = 3'd7;
  localparam logic [vtp_pkg::COORD_W-1:0]   COORD_MAX      = 32'h7FFF_FFFF;
  localparam logic [vtp_pkg::COORD_W-1:0]   COORD_MIN      = 32'h8000_0000;
  localparam logic [vtp_pkg::COORD_W-1:0]   ONE_Q16        = 32'h0001_0000;
  localparam logic [vtp_pkg::COEF_W-1:0]    ONE_Q12        = 16'h1000;
  localparam logic [vtp_pkg::COEF_W-1:0]    COEF_MAX       = 16'h7FFF;
  localparam logic [vtp_pkg::COEF_W-1:0]    COEF_MIN       = 16'h8000;
  localparam longint                        SAT_HI         = 64'sd2147483647;
  localparam longint                        SAT_LO         = -64'sd2147483648;

  // One projected vertex, in port order
  typedef struct packed {
    logic signed [vtp_pkg::COORD_W-1:0] screen_x;
    logic signed [vtp_pkg::COORD_W-1:0] screen_y;
    logic signed [vtp_pkg::COORD_W-1:0] depth;
    logic                               zero_depth;
    logic                               overflowed;
  } vertex_result_t;

  // ---------------------------------------------------------------------------
  // Clock, reset and DUT
  // ---------------------------------------------------------------------------
  logic                               clk_i;
  logic                               rst_ni      = 1'b0;
  logic                               start_i     = 1'b0;
  logic                               busy_o;
  logic signed [vtp_pkg::COORD_W-1:0] point_x_i   = '0;
  logic signed [vtp_pkg::COORD_W-1:0] point_y_i   = '0;
  logic signed [vtp_pkg::COORD_W-1:0] point_z_i   = '0;
  logic                               out_valid_o;
  logic signed [vtp_pkg::COORD_W-1:0] screen_x_o;
  logic signed [vtp_pkg::COORD_W-1:0] screen_y_o;
  logic signed [vtp_pkg::COORD_W-1:0] depth_o;
  logic                               zero_depth_o;
  logic                               overflowed_o;
  logic                               cfg_valid_i = 1'b0;
  logic                               cfg_ready_o;
  logic [vtp_pkg::CFG_IDX_W-1:0]      cfg_index_i = '0;
  logic [vtp_pkg::ROW_W-1:0]          cfg_data_i  = '0;

  // 8 ns period
  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  vertex_transform_project DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .point_x_i    (point_x_i),
    .point_y_i    (point_y_i),
    .point_z_i    (point_z_i),
    .out_valid_o  (out_valid_o),
    .screen_x_o   (screen_x_o),
    .screen_y_o   (screen_y_o),
    .depth_o      (depth_o),
    .zero_depth_o (zero_depth_o),
    .overflowed_o (overflowed_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  // ---------------------------------------------------------------------------
  // Shadow copy of the registers, as the predictor sees them
  // ---------------------------------------------------------------------------
  logic [vtp_pkg::ROW_W-1:0]          mat_row [vtp_pkg::AXES];
  logic signed [vtp_pkg::COORD_W-1:0] offset  [vtp_pkg::AXES];
  logic [vtp_pkg::FOCAL_W-1:0]        focal_len;

  vertex_result_t pending_q [$];   // projections still owed by the pipe
  int unsigned    sender_idle_pct = 0;
  int unsigned    fail_count      = 0;
  int unsigned    n_points        = 0;
  int unsigned    n_cfg_writes    = 0;
  int unsigned    n_zero_seen     = 0;
  int unsigned    n_ovf_seen      = 0;

  function automatic longint clamp32(longint v, inout bit ovf);
    if (v > SAT_HI) begin
      ovf = 1'b1;
      return SAT_HI;
    end
    if (v < SAT_LO) begin
      ovf = 1'b1;
      return SAT_LO;
    end
    return v;
  endfunction

  // Row vector times matrix (rounded half up to Q16.16), plus translation,
  // then -d*x'/z' truncated toward zero. Everything fits in 64 bits.
  function automatic vertex_result_t project_point(logic signed [vtp_pkg::COORD_W-1:0] px,
                                                   logic signed [vtp_pkg::COORD_W-1:0] py,
                                                   logic signed [vtp_pkg::COORD_W-1:0] pz);
    longint                            pt [vtp_pkg::AXES];
    longint                            tr [vtp_pkg::AXES];
    longint                            acc;
    longint                            d;
    longint                            sx;
    longint                            sy;
    logic signed [vtp_pkg::COEF_W-1:0] k0;
    logic signed [vtp_pkg::COEF_W-1:0] k1;
    logic signed [vtp_pkg::COEF_W-1:0] k2;
    bit                                ovf;
    vertex_result_t                    r;
    pt[0] = px;
    pt[1] = py;
    pt[2] = pz;
    ovf   = 1'b0;
    sx    = 0;
    sy    = 0;
    for (int c = 0; c < vtp_pkg::AXES; c++) begin
      k0    = mat_row[0][c*vtp_pkg::COEF_W +: vtp_pkg::COEF_W];
      k1    = mat_row[1][c*vtp_pkg::COEF_W +: vtp_pkg::COEF_W];
      k2    = mat_row[2][c*vtp_pkg::COEF_W +: vtp_pkg::COEF_W];
      acc   = pt[0] * k0 + pt[1] * k1 + pt[2] * k2;
      acc   = ((acc + (longint'(1) <<< (vtp_pkg::ROUND_SHIFT - 1))) >>> vtp_pkg::ROUND_SHIFT)
            + offset[c];
      tr[c] = clamp32(acc, ovf);
    end
    d = longint'(focal_len);
    if (tr[2] != 0) begin
      sx = clamp32(-((d * tr[0]) / tr[2]), ovf);
      sy = clamp32(-((d * tr[1]) / tr[2]), ovf);
    end
    r.screen_x   = sx[vtp_pkg::COORD_W-1:0];
    r.screen_y   = sy[vtp_pkg::COORD_W-1:0];
    r.depth      = tr[2][vtp_pkg::COORD_W-1:0];
    r.zero_depth = (tr[2] == 0);
    r.overflowed = ovf;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Random value helpers
  // ---------------------------------------------------------------------------
  function automatic logic [vtp_pkg::COORD_W-1:0] rand_coord();
    case ($urandom_range(9))
      0:       return '0;
      1: begin
        case ($urandom_range(3))
          0:       return COORD_MAX;
          1:       return COORD_MIN;
          2:       return 32'd1;
          default: return '1;
        endcase
      end
      2, 3, 4: return $urandom;
      default: return 32'($urandom_range(0, 1 << 23) - (1 << 22)); // within +/-64.0
    endcase
  endfunction

  function automatic logic [vtp_pkg::COEF_W-1:0] rand_coef();
    case ($urandom_range(9))
      0:       return '0;
      1:       return COEF_MAX;
      2:       return COEF_MIN;
      3, 4:    return 16'($urandom);
      default: return 16'($urandom_range(0, 8192) - 4096);          // within +/-1.0
    endcase
  endfunction

  function automatic logic [vtp_pkg::FOCAL_W-1:0] rand_focal();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      2:       return vtp_pkg::FOCAL_W'(ONE_Q16);
      3:       return vtp_pkg::FOCAL_W'($urandom);
      default: return vtp_pkg::FOCAL_W'($urandom_range(1, 1 << 20));
    endcase
  endfunction

  function automatic int unsigned draw_gap();
    int unsigned g;
    g = 0;
    while ($urandom_range(99) < sender_idle_pct && g < 50) g++;
    return g;
  endfunction

  // ---------------------------------------------------------------------------
  // Shared drivers. All are entered on a rising edge and return on one.
  // ---------------------------------------------------------------------------
  // start_i is left high on return, so back-to-back points need no extra edge
  task automatic send_point(logic signed [vtp_pkg::COORD_W-1:0] x,
                            logic signed [vtp_pkg::COORD_W-1:0] y,
                            logic signed [vtp_pkg::COORD_W-1:0] z);
    int unsigned gap;
    gap = draw_gap();
    if (gap != 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i   <= 1'b1;
    point_x_i <= x;
    point_y_i <= y;
    point_z_i <= z;
    do @(posedge clk_i); while (busy_o);
    pending_q.push_back(project_point(x, y, z));
    n_points++;
  endtask

  // Register writes are only legal with the pipe empty
  task automatic wait_idle();
    start_i <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic write_reg(logic [vtp_pkg::CFG_IDX_W-1:0] idx,
                           logic [vtp_pkg::ROW_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      vtp_pkg::REG_ROW_ONE:   mat_row[0] = data;
      vtp_pkg::REG_ROW_TWO:   mat_row[1] = data;
      vtp_pkg::REG_ROW_THREE: mat_row[2] = data;
      vtp_pkg::REG_SHIFT_X:   offset[0]  = data[vtp_pkg::COORD_W-1:0];
      vtp_pkg::REG_SHIFT_Y:   offset[1]  = data[vtp_pkg::COORD_W-1:0];
      vtp_pkg::REG_SHIFT_Z:   offset[2]  = data[vtp_pkg::COORD_W-1:0];
      vtp_pkg::REG_FOCAL:     focal_len  = data[vtp_pkg::FOCAL_W-1:0];
      default:                ;
    endcase
    n_cfg_writes++;
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Random setting; upper data bits are random to check the width masks.
  // A plain z column (0, 0, 1.0, no shift) lets zero depth turn up by chance.
  task automatic randomise_setup(bit plain_z);
    logic [vtp_pkg::ROW_W-1:0] row;
    for (int r = 0; r < vtp_pkg::AXES; r++) begin
      row = {rand_coef(), rand_coef(), rand_coef()};
      if (plain_z) row[2*vtp_pkg::COEF_W +: vtp_pkg::COEF_W] = (r == 2) ? ONE_Q12 : '0;
      write_reg(vtp_pkg::CFG_IDX_W'(vtp_pkg::REG_ROW_ONE + r), row);
    end
    write_reg(vtp_pkg::REG_SHIFT_X, {16'($urandom), rand_coord()});
    write_reg(vtp_pkg::REG_SHIFT_Y, {16'($urandom), rand_coord()});
    write_reg(vtp_pkg::REG_SHIFT_Z,
              {16'($urandom), plain_z ? vtp_pkg::COORD_W'(0) : rand_coord()});
    write_reg(vtp_pkg::REG_FOCAL, {16'($urandom), 1'($urandom), rand_focal()});
    if ($urandom_range(3) == 0) write_reg(UNMAPPED_INDEX, {16'($urandom), 32'($urandom)});
  endtask

  // ---------------------------------------------------------------------------
  // Result checker: every strobe must match the oldest outstanding projection
  // ---------------------------------------------------------------------------
  vertex_result_t got_r;
  vertex_result_t want_r;

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o) begin
      got_r = {screen_x_o, screen_y_o, depth_o, zero_depth_o, overflowed_o};
      if (got_r.zero_depth === 1'b1) n_zero_seen++;
      if (got_r.overflowed === 1'b1) n_ovf_seen++;
      if (pending_q.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("%t: unexpected result sx=%h sy=%h depth=%h zero=%b ovf=%b", $realtime,
                   got_r.screen_x, got_r.screen_y, got_r.depth, got_r.zero_depth,
                   got_r.overflowed);
      end else begin
        want_r = pending_q.pop_front();
        if (got_r.screen_x !== want_r.screen_x || got_r.screen_y !== want_r.screen_y ||
            got_r.depth !== want_r.depth || got_r.zero_depth !== want_r.zero_depth ||
            got_r.overflowed !== want_r.overflowed) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("%t: mismatch, expected sx=%h sy=%h depth=%h zero=%b ovf=%b", $realtime,
                     want_r.screen_x, want_r.screen_y, want_r.depth, want_r.zero_depth,
                     want_r.overflowed);
            $display("%t:           actual   sx=%h sy=%h depth=%h zero=%b ovf=%b", $realtime,
                     got_r.screen_x, got_r.screen_y, got_r.depth, got_r.zero_depth,
                     got_r.overflowed);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Reset values: identity matrix, no translation, d = 1.0
  task automatic test_reset_identity();
    send_point(0, 0, 0);                                  // zero depth
    send_point(ONE_Q16, 2 * ONE_Q16, ONE_Q16);
    send_point(COORD_MAX, COORD_MIN, 1);                  // screen saturates
    send_point(COORD_MIN, COORD_MAX, COORD_MIN);
    send_point(-3 * ONE_Q16, 5 * ONE_Q16, -2 * ONE_Q16);
    send_point(32'h0001_2345, -32'h777, COORD_MAX);
  endtask

  // m11 of one LSB: x' = x/4096 rounded, halves go up (so -0.5 goes to 0)
  task automatic test_rounding();
    wait_idle();
    write_reg(vtp_pkg::REG_ROW_ONE, 48'h0000_0000_0001);
    send_point(2048, 0, ONE_Q16);
    send_point(-2048, 0, ONE_Q16);
    send_point(2047, 0, ONE_Q16);
    send_point(-2049, 0, ONE_Q16);
  endtask

  // Transformed coordinates beyond 32 bits, with extreme coefficients and shifts
  task automatic test_saturation();
    wait_idle();
    write_reg(vtp_pkg::REG_ROW_ONE,   {3{COEF_MAX}});
    write_reg(vtp_pkg::REG_ROW_TWO,   {3{COEF_MAX}});
    write_reg(vtp_pkg::REG_ROW_THREE, {3{COEF_MAX}});
    write_reg(vtp_pkg::REG_SHIFT_X, {16'h0, COORD_MAX});
    write_reg(vtp_pkg::REG_SHIFT_Y, {16'h0, COORD_MAX});
    write_reg(vtp_pkg::REG_SHIFT_Z, {16'h0, COORD_MAX});
    send_point(COORD_MAX, COORD_MAX, COORD_MAX);
    wait_idle();
    write_reg(vtp_pkg::REG_ROW_ONE,   {3{COEF_MIN}});
    write_reg(vtp_pkg::REG_ROW_TWO,   {3{COEF_MIN}});
    write_reg(vtp_pkg::REG_ROW_THREE, {3{COEF_MIN}});
    write_reg(vtp_pkg::REG_SHIFT_X, {16'h0, COORD_MIN});
    write_reg(vtp_pkg::REG_SHIFT_Y, {16'h0, COORD_MIN});
    write_reg(vtp_pkg::REG_SHIFT_Z, {16'h0, COORD_MIN});
    send_point(COORD_MIN, COORD_MIN, COORD_MIN);
    send_point(COORD_MAX, COORD_MAX, COORD_MAX);
    send_point(ONE_Q16, -ONE_Q16, 0);
  endtask

  // Focal extremes, width masking of writes, and the unmapped index
  task automatic test_focal_and_masking();
    wait_idle();
    write_reg(vtp_pkg::REG_ROW_ONE,   48'h0000_0000_1000);
    write_reg(vtp_pkg::REG_ROW_TWO,   48'h0000_1000_0000);
    write_reg(vtp_pkg::REG_ROW_THREE, 48'h1000_0000_0000);
    write_reg(vtp_pkg::REG_SHIFT_X, 48'hABCD_0001_0000);  // 1.0 once masked
    write_reg(vtp_pkg::REG_SHIFT_Y, 48'h8000_FFFF_FFFF);  // -1 LSB once masked
    write_reg(vtp_pkg::REG_SHIFT_Z, 48'hFFFF_0000_0000);  // zero once masked
    write_reg(vtp_pkg::REG_FOCAL,   48'hFFFF_FFFF_FFFF);  // largest d
    write_reg(UNMAPPED_INDEX, 48'h5A5A_A5A5_5A5A);
    send_point(ONE_Q16, ONE_Q16, -ONE_Q16);
    send_point(-7 * ONE_Q16, 3 * ONE_Q16, 1);
    wait_idle();
    write_reg(vtp_pkg::REG_FOCAL, 48'hFFFF_8000_0000);    // d = 0 once masked
    send_point(5 * ONE_Q16, -7 * ONE_Q16, 3 * ONE_Q16);
    send_point(-ONE_Q16, 0, 0);                           // zero depth
  endtask

  // Blocks of random points, each under a fresh random setting
  task automatic test_random_traffic(int unsigned idle_pct, int unsigned blocks,
                                     int unsigned per_block);
    sender_idle_pct = idle_pct;
    for (int b = 0; b < blocks; b++) begin
      wait_idle();
      randomise_setup(b % 3 == 0);
      repeat (per_block) send_point(rand_coord(), rand_coord(), rand_coord());
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    mat_row[0] = 48'h0000_0000_1000;
    mat_row[1] = 48'h0000_1000_0000;
    mat_row[2] = 48'h1000_0000_0000;
    offset[0]  = '0;
    offset[1]  = '0;
    offset[2]  = '0;
    focal_len  = vtp_pkg::FOCAL_W'(ONE_Q16);
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_identity();
    test_rounding();
    test_saturation();
    test_focal_and_masking();
    test_random_traffic(0, 5, 65);    // back to back
    test_random_traffic(80, 5, 65);   // sparse sender
    test_random_traffic(0, 5, 65);    // receiver cannot stall: plain streaming again
    test_random_traffic(21, 5, 65);   // light gaps

    // drain, then keep watching for stray strobes
    wait_idle();
    repeat (vtp_pkg::PIPE_DEPTH + 8) @(posedge clk_i);
    if (pending_q.size() != 0) begin
      fail_count += pending_q.size();
      $display("%0d projections never returned", pending_q.size());
    end

    $display("Sent %0d points across %0d register writes and four traffic phases;",
             n_points, n_cfg_writes);
    $display("saw %0d zero-depth and %0d saturated results, %0d failures.",
             n_zero_seen, n_ovf_seen, fail_count);
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
